// ===== rtl/plasma_pixel_generator_defines.svh =====
// ----------------------------------------------------------------------------
// plasma pixel generator assertion macros
// shared property wrappers for the plasma pipeline checks
// ----------------------------------------------------------------------------
`ifndef PLASMA_PIXEL_GENERATOR_DEFINES_SVH
`define PLASMA_PIXEL_GENERATOR_DEFINES_SVH

// same-cycle implication, clocked on clk and held off during reset
`define PPG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk and held off during reset
`define PPG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ppg_pkg.sv =====
// ----------------------------------------------------------------------------
// ppg_pkg
// types, constants and helpers shared by the plasma pixel pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppg_pkg;

  // phase and frequency scalers (Q16 turns)
  localparam logic [26:0] K_TIME  = 27'd104995626;
  localparam logic [16:0] K_DOT   = 17'd106807;
  localparam logic [17:0] K_RING  = 18'd160211;

  // quarter-wave polynomial coefficients, Q30
  localparam logic [30:0] C9 = 31'd172272;
  localparam logic [30:0] POLY_COEF [4] = '{31'd5026995, 31'd85569306,
                                             31'd693598668, 31'd1686629713};

  localparam logic [15:0] QUARTER   = 16'd16384;
  localparam int unsigned SIN_LAT   = 7;
  localparam int unsigned SQRT_STEPS = 27;

  typedef logic signed [16:0] trig_t;

  // one beat through a polynomial cell
  typedef struct packed {
    logic [30:0] x;
    logic [30:0] x2;
    logic [30:0] p;
    logic        neg;
  } poly_beat_t;

  // one beat through a square root cell
  typedef struct packed {
    logic [53:0] n;
    logic [53:0] res;
  } sqrt_beat_t;

  // (v + 32768) >> 1
  function automatic logic [15:0] half_term(trig_t v);
    logic signed [17:0] t;
    t = 18'(v) + 18'sd32768;
    return t[16:1];
  endfunction

  // ((v + 32768) * 255) >> 16
  function automatic logic [7:0] to_channel(trig_t v);
    logic signed [17:0] t;
    logic [24:0] m;
    t = 18'(v) + 18'sd32768;
    m = 25'(t[16:0]) * 25'd255;
    return m[23:16];
  endfunction

endpackage

// ===== rtl/ppg_if.sv =====
// ----------------------------------------------------------------------------
// ppg channel interfaces
// valid/ready channels for pixel requests and colour results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ppg_pixel_if;
  logic        valid;
  logic        ready;
  logic [8:0]  pixel_x;
  logic [7:0]  pixel_y;
  logic [21:0] frame_time_ms;

  modport source (output valid, pixel_x, pixel_y, frame_time_ms, input ready);
  modport sink   (input valid, pixel_x, pixel_y, frame_time_ms, output ready);
endinterface

interface ppg_colour_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

// ===== rtl/plasma_pixel_generator.sv =====
// ----------------------------------------------------------------------------
// plasma pixel generator
// one plasma pixel colour per beat from column, row and animation time
// ----------------------------------------------------------------------------
// in_pix carries pixel_x, pixel_y and frame_time_ms; out_pix returns red,
// green and blue. Both are valid/ready channels and a beat moves when both
// are high.
// The datapath is a fixed pipeline of 55 register stages: phase multiply,
// a sine row, the dot and distance products, a 27-cell square root row,
// two more sine rows and the colour scaling.
// Throughput is one pixel per cycle while the output is not stalled; every
// stage is a register, the depth is set by the square root row and the
// three sine pipelines.
// While out_pix holds a beat that is not taken, the whole pipeline holds
// and in_pix.ready drops; when the output is taken or empty, the pipeline
// advances and a new request is taken in the same cycle.
// Reset clears the stage valid bits only, so no result is produced until
// a request has travelled the full depth.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "plasma_pixel_generator_defines.svh"

module plasma_pixel_generator (
  input  logic                clk,
  input  logic                rst_n,
  ppg_pixel_if.sink           in_pix,
  ppg_colour_if.source        out_pix
);
  import ppg_pkg::*;

  // stage positions along the pipeline
  localparam int unsigned ST_T3   = 1;
  localparam int unsigned ST_TRIG = ST_T3 + SIN_LAT;
  localparam int unsigned ST_DOT  = ST_TRIG + 1;
  localparam int unsigned ST_ANG1 = ST_DOT + 1;
  localparam int unsigned ST_SUM  = ST_ANG1 + 1;
  localparam int unsigned ST_DIST = ST_SUM + SQRT_STEPS;
  localparam int unsigned ST_ANG2 = ST_DIST + 1;
  localparam int unsigned ST_TERM = ST_ANG2 + SIN_LAT;
  localparam int unsigned ST_MIX  = ST_TERM + 1;
  localparam int unsigned ST_COL  = ST_MIX + SIN_LAT;
  localparam int unsigned LAT     = ST_COL + 1;

  logic               ce;
  logic [LAT:1]       vld_r;

  logic [48:0]        t_prod;
  logic [15:0]        t3_r;
  logic [8:0]         px_r;
  logic [7:0]         py_r;
  trig_t              st;
  trig_t              ct;
  logic [16:0]        pxy_trig;

  logic signed [27:0] pxs;
  logic signed [27:0] pys;
  logic signed [27:0] dot_r;
  logic signed [27:0] dx_r;
  logic signed [27:0] dy_r;

  logic signed [45:0] dot_prod;
  logic signed [53:0] dx_sq;
  logic signed [53:0] dy_sq;
  logic [15:0]        a1_r;
  logic [53:0]        dx2_r;
  logic [53:0]        dy2_r;
  logic [53:0]        n_r;

  sqrt_beat_t         sq_beat [SQRT_STEPS+1];
  logic [43:0]        ring_prod;
  logic [15:0]        a2_r;
  logic [15:0]        a1_dly;
  logic [15:0]        t3_ang;
  logic [15:0]        t3_term;
  trig_t              term1;
  trig_t              term2;
  logic [15:0]        ac_r;
  trig_t              col_cos;
  trig_t              col_sin;
  logic [16:0]        st_col;
  logic [7:0]         red_r;
  logic [7:0]         green_r;
  logic [7:0]         blue_r;

  // the pipeline moves unless a held result blocks it
  assign ce           = !vld_r[LAT] || out_pix.ready;
  assign in_pix.ready = ce;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[LAT-1:1], in_pix.valid};
    end
  end

  // phase t3 and captured coordinates
  assign t_prod = 49'(in_pix.frame_time_ms) * 49'(K_TIME);

  always_ff @(posedge clk) begin
    if (ce) begin
      t3_r <= t_prod[39:24];
      px_r <= in_pix.pixel_x;
      py_r <= in_pix.pixel_y;
    end
  end

  // sin t3 and cos t3
  ppg_sine u_sin_t3 (.clk(clk), .ce(ce), .angle_i(t3_r), .val_o(st));
  ppg_sine u_cos_t3 (.clk(clk), .ce(ce), .angle_i(t3_r + QUARTER), .val_o(ct));

  ppg_delay #(.WIDTH(17), .DEPTH(ST_TRIG - ST_T3)) u_dly_xy (
    .clk(clk), .ce(ce), .d_i({px_r, py_r}), .q_o(pxy_trig)
  );

  // dot product and offsets to the moving centre
  assign pxs = 28'(signed'({1'b0, pxy_trig[16:8], 1'b0}));
  assign pys = 28'(signed'({1'b0, pxy_trig[7:0], 1'b0}));

  always_ff @(posedge clk) begin
    if (ce) begin
      dot_r <= pxs * 28'(st) + pys * 28'(ct);
      dx_r  <= (pxs <<< 15) - 28'sd10485760 + 28'sd320 * 28'(st);
      dy_r  <= (pys <<< 15) - 28'sd5898240 - 28'sd180 * 28'(ct);
    end
  end

  // wave angle and squared offsets
  assign dot_prod = 46'(dot_r) * 46'(signed'({1'b0, K_DOT}));
  assign dx_sq    = 54'(dx_r) * 54'(dx_r);
  assign dy_sq    = 54'(dy_r) * 54'(dy_r);

  always_ff @(posedge clk) begin
    if (ce) begin
      a1_r  <= dot_prod[39:24];
      dx2_r <= dx_sq;
      dy2_r <= dy_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      n_r <= dx2_r + dy2_r;
    end
  end

  // square root row, two radicand bits per cell
  assign sq_beat[0].n   = n_r;
  assign sq_beat[0].res = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    ppg_sqrt_cell #(.BIT_POS(2 * (SQRT_STEPS - 1 - k))) u_cell (
      .clk    (clk),
      .ce     (ce),
      .beat_i (sq_beat[k]),
      .beat_o (sq_beat[k+1])
    );
  end

  // ring angle
  assign ring_prod = 44'(sq_beat[SQRT_STEPS].res[25:0]) * 44'(K_RING);

  always_ff @(posedge clk) begin
    if (ce) begin
      a2_r <= ring_prod[39:24];
    end
  end

  ppg_delay #(.WIDTH(16), .DEPTH(ST_ANG2 - ST_ANG1)) u_dly_a1 (
    .clk(clk), .ce(ce), .d_i(a1_r), .q_o(a1_dly)
  );

  ppg_delay #(.WIDTH(16), .DEPTH(ST_ANG2 - ST_T3)) u_dly_t3a (
    .clk(clk), .ce(ce), .d_i(t3_r), .q_o(t3_ang)
  );

  ppg_delay #(.WIDTH(16), .DEPTH(ST_TERM - ST_ANG2)) u_dly_t3b (
    .clk(clk), .ce(ce), .d_i(t3_ang), .q_o(t3_term)
  );

  // wave and ring terms
  ppg_sine u_wave (.clk(clk), .ce(ce), .angle_i(a1_dly + t3_ang), .val_o(term1));
  ppg_sine u_ring (.clk(clk), .ce(ce), .angle_i(a2_r + QUARTER), .val_o(term2));

  // colour angle, sums wrap in turns
  always_ff @(posedge clk) begin
    if (ce) begin
      ac_r <= half_term(term1) + half_term(term2) + t3_term;
    end
  end

  ppg_sine u_col_cos (.clk(clk), .ce(ce), .angle_i(ac_r + QUARTER), .val_o(col_cos));
  ppg_sine u_col_sin (.clk(clk), .ce(ce), .angle_i(ac_r), .val_o(col_sin));

  ppg_delay #(.WIDTH(17), .DEPTH(ST_COL - ST_TRIG)) u_dly_st (
    .clk(clk), .ce(ce), .d_i(st), .q_o(st_col)
  );

  // output register
  always_ff @(posedge clk) begin
    if (ce) begin
      red_r   <= to_channel(col_cos);
      green_r <= to_channel(col_sin);
      blue_r  <= to_channel(signed'(st_col));
    end
  end

  assign out_pix.valid = vld_r[LAT];
  assign out_pix.red   = red_r;
  assign out_pix.green = green_r;
  assign out_pix.blue  = blue_r;

  // checks
  `PPG_ASSERT_IMP(a_trig_range, vld_r[ST_TRIG], (st >= -17'sd32768) && (st <= 17'sd32768) && (ct >= -17'sd32768) && (ct <= 17'sd32768), "sine of t3 out of range")
  `PPG_ASSERT_IMP(a_dist_fits, vld_r[ST_DIST], sq_beat[SQRT_STEPS].res[53:26] == '0, "distance wider than 26 bits")
  `PPG_ASSERT_NXT(a_stall_hold, !ce, $stable(vld_r), "pipeline moved while stalled")
  `PPG_ASSERT_IMP(a_out_origin, $rose(vld_r[LAT]), $past(vld_r[LAT-1]), "result without a pipeline beat")

endmodule

// ===== rtl/ppg_delay.sv =====
// ----------------------------------------------------------------------------
// ppg_delay
// stallable shift line that keeps side data aligned with the pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppg_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk,
  input  logic             ce,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  // shift on every advancing cycle
  always_ff @(posedge clk) begin
    if (ce) begin
      tap_r[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q_o = tap_r[DEPTH-1];

endmodule

// ===== rtl/ppg_poly_cell.sv =====
// ----------------------------------------------------------------------------
// ppg_poly_cell
// one horner step of the quarter-wave polynomial: p = coef - x2 * p
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppg_poly_cell #(
  parameter logic [30:0] COEF = 31'd0
) (
  input  logic                clk,
  input  logic                ce,
  input  ppg_pkg::poly_beat_t beat_i,
  output ppg_pkg::poly_beat_t beat_o
);
  import ppg_pkg::*;

  logic [61:0] prod;
  logic [31:0] diff;
  poly_beat_t  beat_r;

  // truncated q30 product, subtracted from the coefficient
  always_comb begin
    prod = 62'(beat_i.x2) * 62'(beat_i.p);
    diff = {1'b0, COEF} - prod[61:30];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      beat_r.x   <= beat_i.x;
      beat_r.x2  <= beat_i.x2;
      beat_r.p   <= diff[30:0];
      beat_r.neg <= beat_i.neg;
    end
  end

  assign beat_o = beat_r;

endmodule

// ===== rtl/ppg_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// ppg_sqrt_cell
// one digit of the restoring integer square root
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppg_sqrt_cell #(
  parameter int unsigned BIT_POS = 0
) (
  input  logic                clk,
  input  logic                ce,
  input  ppg_pkg::sqrt_beat_t beat_i,
  output ppg_pkg::sqrt_beat_t beat_o
);
  import ppg_pkg::*;

  localparam logic [53:0] BIT_VAL = 54'd1 << BIT_POS;

  logic [53:0] trial;
  sqrt_beat_t  beat_nxt;
  sqrt_beat_t  beat_r;

  // try this digit, keep the remainder if it fits
  always_comb begin
    trial = beat_i.res + BIT_VAL;
    if (beat_i.n >= trial) begin
      beat_nxt.n   = beat_i.n - trial;
      beat_nxt.res = (beat_i.res >> 1) + BIT_VAL;
    end else begin
      beat_nxt.n   = beat_i.n;
      beat_nxt.res = beat_i.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      beat_r <= beat_nxt;
    end
  end

  assign beat_o = beat_r;

endmodule

// ===== rtl/ppg_sine.sv =====
// ----------------------------------------------------------------------------
// ppg_sine
// pipelined Q15 sine of a Q16 angle, quarter-wave polynomial over a cell row
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppg_sine (
  input  logic           clk,
  input  logic           ce,
  input  logic [15:0]    angle_i,
  output ppg_pkg::trig_t val_o
);
  import ppg_pkg::*;

  logic [1:0]  quad;
  logic [14:0] u;
  logic [30:0] x;
  logic [61:0] sq;
  poly_beat_t  beat [5];
  poly_beat_t  s0_r;
  logic [61:0] fin;
  logic [16:0] mag_r;
  logic        neg_r;
  logic [16:0] mag_sat;
  trig_t       val_r;

  // fold into the first quadrant and square
  always_comb begin
    quad = angle_i[15:14];
    u    = quad[0] ? 15'(QUARTER - {2'b00, angle_i[13:0]}) : {1'b0, angle_i[13:0]};
    x    = {u, 16'h0000};
    sq   = 62'(x) * 62'(x);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s0_r.x   <= x;
      s0_r.x2  <= sq[60:30];
      s0_r.p   <= C9;
      s0_r.neg <= quad[1];
    end
  end

  assign beat[0] = s0_r;

  // horner row
  for (genvar i = 0; i < 4; i++) begin : g_poly
    ppg_poly_cell #(.COEF(POLY_COEF[i])) u_cell (
      .clk    (clk),
      .ce     (ce),
      .beat_i (beat[i]),
      .beat_o (beat[i+1])
    );
  end

  // final multiply by x
  assign fin = 62'(beat[4].x) * 62'(beat[4].p);

  always_ff @(posedge clk) begin
    if (ce) begin
      mag_r <= fin[61:45];
      neg_r <= beat[4].neg;
    end
  end

  // saturate at one and apply the half-wave sign
  assign mag_sat = (mag_r > 17'd32768) ? 17'd32768 : mag_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      val_r <= neg_r ? -$signed(mag_sat) : $signed(mag_sat);
    end
  end

  assign val_o = val_r;

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// plasma pixel generator testbench
// drives pixel requests through the valid/ready input channel, predicts each
// colour beat with a bit-exact fixed-point model and compares it on output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  // phase and frequency scalers, Q16 turns
  localparam logic [63:0] PHASE_SCALE = 64'd104995626;
  localparam logic [63:0] WAVE_SCALE  = 64'd106807;
  localparam logic [63:0] RING_SCALE  = 64'd160211;

  // quarter-wave polynomial coefficients, Q30
  localparam logic [63:0] Q_C1 = 64'd1686629713;
  localparam logic [63:0] Q_C3 = 64'd693598668;
  localparam logic [63:0] Q_C5 = 64'd85569306;
  localparam logic [63:0] Q_C7 = 64'd5026995;
  localparam logic [63:0] Q_C9 = 64'd172272;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned PIPE_DEPTH  = 55;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } colour_t;

  logic clk;
  logic rst_n;

  ppg_pixel_if  in_if ();
  ppg_colour_if out_if ();

  plasma_pixel_generator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_if),
    .out_pix (out_if)
  );

  colour_t     colour_q[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // quarter wave sin(pi/2 * u / 16384), Q15, truncated Horner in Q30
  function automatic logic [63:0] quarter_wave(logic [63:0] u);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] s;
    x  = u << 16;
    x2 = (x * x) >> 30;
    p  = Q_C9;
    p  = Q_C7 - ((x2 * p) >> 30);
    p  = Q_C5 - ((x2 * p) >> 30);
    p  = Q_C3 - ((x2 * p) >> 30);
    p  = Q_C1 - ((x2 * p) >> 30);
    s  = ((x * p) >> 30) >> 15;
    if (s > 64'd32768) s = 64'd32768;
    return s;
  endfunction

  // sine of a Q16 turn angle, signed Q15
  function automatic longint turn_sin(logic [15:0] ang);
    logic [63:0] v;
    if (ang[14]) v = quarter_wave(64'd16384 - 64'(ang[13:0]));
    else v = quarter_wave(64'(ang[13:0]));
    return ang[15] ? -longint'(v) : longint'(v);
  endfunction

  function automatic longint turn_cos(logic [15:0] ang);
    return turn_sin(ang + 16'd16384);
  endfunction

  // bitwise integer square root
  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bit_v;
    res   = '0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n   = n - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic logic [7:0] scale_channel(longint v);
    logic [63:0] m;
    m = 64'(v + 32768) * 64'd255;
    return m[23:16];
  endfunction

  // expected colour of one pixel
  function automatic colour_t plasma_colour(logic [8:0] px, logic [7:0] py,
                                            logic [21:0] ms);
    logic [63:0] prod;
    logic [15:0] t3;
    logic [15:0] wave_ang;
    logic [15:0] ring_ang;
    logic [15:0] col_ang;
    longint      st;
    longint      ct;
    longint      dot;
    longint      dx;
    longint      dy;
    longint      wave_term;
    longint      ring_term;
    logic [63:0] ring_dist;
    colour_t     c;
    prod = 64'(ms) * PHASE_SCALE;
    t3   = prod[39:24];
    st   = turn_sin(t3);
    ct   = turn_cos(t3);
    // rotating wave
    dot       = 2 * longint'(px) * st + 2 * longint'(py) * ct;
    prod      = 64'(dot) * WAVE_SCALE;
    wave_ang  = prod[39:24];
    wave_term = (turn_sin(wave_ang + t3) + 32768) >>> 1;
    // ring around the moving centre
    dx        = 2 * longint'(px) * 32768 - 320 * 32768 + 320 * st;
    dy        = 2 * longint'(py) * 32768 - 180 * 32768 - 180 * ct;
    ring_dist = int_sqrt(64'(dx * dx) + 64'(dy * dy));
    prod      = ring_dist * RING_SCALE;
    ring_ang  = prod[39:24];
    ring_term = (turn_cos(ring_ang) + 32768) >>> 1;
    col_ang = 16'(wave_term + ring_term) + t3;
    c.red   = scale_channel(turn_cos(col_ang));
    c.green = scale_channel(turn_sin(col_ang));
    c.blue  = scale_channel(st);
    return c;
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // result checker and watchdog
  always @(posedge clk) begin
    colour_t want;
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles + 1 >= STALL_LIMIT) begin
          $display("watchdog: no beat for %0d cycles, %0d colours pending",
                   STALL_LIMIT, colour_q.size());
          $display("end of test: mismatches");
          $finish;
        end
      end
      if (out_if.valid && out_if.ready) begin
        if (colour_q.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected colour beat r=%0d g=%0d b=%0d",
                     out_if.red, out_if.green, out_if.blue);
        end else begin
          want = colour_q.pop_front();
          if (out_if.red !== want.red || out_if.green !== want.green ||
              out_if.blue !== want.blue) begin
            mismatches = mismatches + 1;
            if (mismatches <= MAX_REPORTS)
              $display("colour mismatch: want r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                       want.red, want.green, want.blue,
                       out_if.red, out_if.green, out_if.blue);
          end
        end
      end
    end
  end

  // send one pixel request; valid stays high until the next request or idle gap
  task automatic send_pixel(logic [8:0] px, logic [7:0] py, logic [21:0] ms);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.pixel_x       <= px;
    in_if.pixel_y       <= py;
    in_if.frame_time_ms <= ms;
    colour_q.push_back(plasma_colour(px, py, ms));
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // hold off until every pending colour has come back
  task automatic drain_colours();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (colour_q.size() != 0) @(posedge clk);
  endtask

  // field extremes, frame edges, beyond-frame coordinates, time wrap
  task automatic test_extremes();
    logic [8:0]  xs [4] = '{9'd0, 9'd319, 9'd320, 9'd511};
    logic [7:0]  ys [3] = '{8'd0, 8'd128, 8'd255};
    logic [21:0] ts [4] = '{22'd0, 22'd3599999, 22'd3600000, 22'h3FFFFF};
    foreach (xs[i]) send_pixel(xs[i], ys[i % 3], ts[i]);
    foreach (ts[i]) send_pixel(9'd160, 8'd90, ts[i]);
    foreach (ys[i]) send_pixel(9'h1FF, ys[i], 22'h2AAAAA);
    send_pixel(9'd0, 8'd255, 22'h155555);
    send_pixel(9'd319, 8'd0, 22'd1);
  endtask

  // random pixels: columns and times mostly in frame and within the hour, rows anywhere
  task automatic test_random(int unsigned count);
    logic [8:0]  px;
    logic [7:0]  py;
    logic [21:0] ms;
    repeat (count) begin
      if ($urandom_range(0, 3) != 0) begin
        px = 9'($urandom_range(0, 319));
        ms = 22'($urandom_range(0, 3599999));
      end else begin
        px = 9'($urandom);
        ms = 22'($urandom);
      end
      py = 8'($urandom);
      send_pixel(px, py, ms);
    end
  endtask

  // one frame time sweeping a short scan line, a pause to empty, then random pixels
  task automatic test_scan_pause();
    logic [21:0] ms;
    ms = 22'($urandom_range(0, 3599999));
    for (int i = 0; i < 20; i++) send_pixel(9'(i * 16), 8'(i * 12), ms);
    drain_colours();
    test_random(10);
  endtask

  initial begin
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.pixel_x       = '0;
    in_if.pixel_y       = '0;
    in_if.frame_time_ms = '0;
    send_idle_pct       = 25;
    recv_idle_pct       = 72;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_random(450);
    test_scan_pause();

    send_idle_pct = 72;
    recv_idle_pct = 25;
    test_random(450);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(450);

    drain_colours();
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (mismatches == 0 && colour_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== plasma_pixel_generator.f =====
+incdir+rtl
rtl/ppg_pkg.sv
rtl/ppg_if.sv
rtl/ppg_delay.sv
rtl/ppg_poly_cell.sv
rtl/ppg_sqrt_cell.sv
rtl/ppg_sine.sv
rtl/plasma_pixel_generator.sv
dv/tb.sv
